FILE: design/cdr_pkg.sv
// Shared types, sizes and helper functions for the cache directory block.
// Every design file but cdr_ram takes this package in with a wildcard import.
package cdr_pkg;

    localparam int WAYS        = 4;
    localparam int MEM_WORDS   = 16;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int MEM_AW      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int TAG_W       = 4;
    localparam int DATA_W      = 32;
    localparam int POL_W       = 2;
    localparam int STAMP_W     = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] MEM_INIT_STEP = DATA_W'(10);

    localparam logic       CMD_WRITE = 1'b1;
    localparam logic [POL_W-1:0] POL_FIFO  = 2'd1;
    localparam logic [POL_W-1:0] POL_CLOCK = 2'd2;

    // One access as it travels from the front end to the back end.
    typedef struct packed {
        logic                     command;
        logic [TAG_W-1:0]         address;
        logic signed [DATA_W-1:0] write_value;
        logic [POL_W-1:0]         policy;
        logic                     thru_mode;
        logic                     hit;
        logic [WAY_W-1:0]         hit_way;
        logic                     has_free;
        logic [WAY_W-1:0]         free_way;
    } t_req;

    // Tag and valid view of the directory used for the lookup.
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tag;
        logic [WAYS-1:0]            valid;
    } t_dir_view;

    typedef struct packed {
        logic                     hit;
        logic [WAY_W-1:0]         way;
        logic signed [DATA_W-1:0] read_data;
        logic                     evicted;
        logic [TAG_W-1:0]         evicted_tag;
        logic                     evicted_dirty;
    } t_result;

    // Next way index with wrap-around at the way count.
    function automatic logic [WAY_W-1:0] way_inc(input logic [WAY_W-1:0] p);
        logic [WAY_W-1:0] r;
        if (p == WAY_W'(WAYS - 1)) begin
            r = '0;
        end else begin
            r = p + WAY_W'(1);
        end
        return r;
    endfunction

    // Address reduced modulo the memory size, as a small constant table.
    function automatic logic [MEM_AW-1:0] mem_index(input logic [TAG_W-1:0] a);
        logic [MEM_AW-1:0] r;
        r = '0;
        for (int k = 0; k < (1 << TAG_W); k++) begin
            if (a == TAG_W'(k)) begin
                r = MEM_AW'(k % MEM_WORDS);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/cdr_ram.sv
// Generic single-port RAM with a registered read port.
// No dependencies; sized by its WIDTH and DEPTH parameters.
module cdr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/cdr_front.sv
// Front end: captures an accepted transaction and classifies it as hit,
// free-way fill or eviction against the directory view. Uses cdr_pkg.
module cdr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_command,
    input  logic [3:0]               i_address,
    input  logic signed [31:0]       i_write_value,
    input  logic [1:0]               i_policy,
    input  logic                     i_thru_mode,
    input  cdr_pkg::t_dir_view       i_dir,
    output logic                     o_push,
    output cdr_pkg::t_req            o_item
);
    import cdr_pkg::*;

    logic r_pending;
    t_req r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= i_accept;
        end
        if (i_accept) begin
            r_req.command       <= i_command;
            r_req.address       <= i_address;
            r_req.write_value   <= i_write_value;
            r_req.policy        <= i_policy;
            r_req.thru_mode     <= i_thru_mode;
            r_req.hit           <= 1'b0;
            r_req.hit_way       <= '0;
            r_req.has_free      <= 1'b0;
            r_req.free_way      <= '0;
        end
    end

    // Lowest matching way and lowest invalid way win.
    always_comb begin
        o_item = r_req;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (i_dir.valid[i] && (i_dir.tag[i] == r_req.address)) begin
                o_item.hit     = 1'b1;
                o_item.hit_way = WAY_W'(i);
            end
            if (!i_dir.valid[i]) begin
                o_item.has_free = 1'b1;
                o_item.free_way = WAY_W'(i);
            end
        end
    end

    assign o_push = r_pending;

endmodule

FILE: design/cdr_queue.sv
// Short FIFO that decouples the front end from the back end.
// Holds cdr_pkg::t_req entries; depth comes from cdr_pkg.
module cdr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cdr_pkg::t_req i_item,
    input  logic          i_pop,
    output logic          o_valid,
    output cdr_pkg::t_req o_item
);
    import cdr_pkg::*;

    t_req                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QCNT_W-1:0]   n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= (r_wp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + QUEUE_AW'(1);
            end
        end
        if (i_push) begin
            r_entry[r_wp] <= i_item;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_item  = r_entry[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && (r_cnt == QCNT_W'(QUEUE_DEPTH))))
        else $error("queue pushed while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("queue popped while empty");

endmodule

FILE: design/cdr_back.sv
// Back end: victim selection (FIFO, clock, LRU scan), directory update,
// memory access and result register. Uses cdr_pkg and cdr_ram.
module cdr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  cdr_pkg::t_req      i_q_item,
    output logic               o_pop,
    output logic               o_idle,
    output cdr_pkg::t_dir_view o_dir,
    output logic               o_done,
    output cdr_pkg::t_result   o_result
);
    import cdr_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_LRU    = 3'd2;
    localparam logic [2:0] ST_CLOCK  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0]                     r_state;
    logic [WAYS-1:0][TAG_W-1:0]     r_tag;
    logic [WAYS-1:0]                r_valid;
    logic [WAYS-1:0]                r_dirty;
    logic [WAYS-1:0]                r_ref;
    logic [WAYS-1:0][STAMP_W-1:0]   r_stamp;
    logic [WAY_W-1:0]               r_clock_ptr;
    logic [WAY_W-1:0]               r_fifo_ptr;
    logic [STAMP_W-1:0]             r_count;
    t_req                           r_req;
    logic [WAY_W-1:0]               r_w;
    logic                           r_evict;
    logic [WAY_W-1:0]               r_scan;
    logic [STAMP_W-1:0]             r_best_stamp;
    logic [MEM_AW-1:0]              r_init_addr;
    logic [DATA_W-1:0]              r_init_val;
    t_result                        r_out;
    logic                           r_out_valid;

    logic                           ram_we;
    logic [MEM_AW-1:0]              ram_addr;
    logic [DATA_W-1:0]              ram_wdata;
    logic [DATA_W-1:0]              ram_rdata;

    cdr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // The memory port is used by the reset fill and by the update step.
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = mem_index(r_req.address);
        ram_wdata = DATA_W'(r_req.write_value);
        if (r_state == ST_INIT) begin
            ram_we    = 1'b1;
            ram_addr  = r_init_addr;
            ram_wdata = r_init_val;
        end else if (r_state == ST_UPDATE) begin
            ram_we = (r_req.command == CMD_WRITE);
        end
    end

    assign o_pop = (r_state == ST_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_tag       <= '0;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_ref       <= '0;
            r_stamp     <= '0;
            r_clock_ptr <= '0;
            r_fifo_ptr  <= '0;
            r_count     <= STAMP_W'(1);
            r_init_addr <= '0;
            r_init_val  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                ST_INIT: begin
                    r_init_addr <= r_init_addr + MEM_AW'(1);
                    r_init_val  <= r_init_val + MEM_INIT_STEP;
                    if (r_init_addr == MEM_AW'(MEM_WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_req <= i_q_item;
                        priority if (i_q_item.hit) begin
                            r_w     <= i_q_item.hit_way;
                            r_evict <= 1'b0;
                            r_state <= ST_UPDATE;
                        end else if (i_q_item.has_free) begin
                            r_w     <= i_q_item.free_way;
                            r_evict <= 1'b0;
                            r_state <= ST_UPDATE;
                        end else if (i_q_item.policy == POL_FIFO) begin
                            r_w        <= r_fifo_ptr;
                            r_fifo_ptr <= way_inc(r_fifo_ptr);
                            r_evict    <= 1'b1;
                            r_state    <= ST_UPDATE;
                        end else if (i_q_item.policy == POL_CLOCK) begin
                            r_scan  <= r_clock_ptr;
                            r_evict <= 1'b1;
                            r_state <= ST_CLOCK;
                        end else begin
                            r_w          <= '0;
                            r_best_stamp <= r_stamp[0];
                            r_scan       <= WAY_W'(1);
                            r_evict      <= 1'b1;
                            r_state      <= ST_LRU;
                        end
                    end
                end
                ST_LRU: begin
                    // Strictly smaller only, so ties stay with the lower way.
                    if (r_stamp[r_scan] < r_best_stamp) begin
                        r_w          <= r_scan;
                        r_best_stamp <= r_stamp[r_scan];
                    end
                    if (r_scan == WAY_W'(WAYS - 1)) begin
                        r_state <= ST_UPDATE;
                    end else begin
                        r_scan <= r_scan + WAY_W'(1);
                    end
                end
                ST_CLOCK: begin
                    if (!r_ref[r_scan]) begin
                        r_w         <= r_scan;
                        r_clock_ptr <= way_inc(r_scan);
                        r_state     <= ST_UPDATE;
                    end else begin
                        r_ref[r_scan] <= 1'b0;
                        r_scan        <= way_inc(r_scan);
                    end
                end
                ST_UPDATE: begin
                    r_out.hit           <= r_req.hit;
                    r_out.way           <= r_w;
                    r_out.evicted       <= r_evict;
                    r_out.evicted_tag   <= r_evict ? r_tag[r_w] : '0;
                    r_out.evicted_dirty <= r_evict && r_dirty[r_w];
                    r_tag[r_w]   <= r_req.address;
                    r_valid[r_w] <= 1'b1;
                    r_dirty[r_w] <= (r_req.hit && r_dirty[r_w]) ||
                                    ((r_req.command == CMD_WRITE) && !r_req.thru_mode);
                    r_stamp[r_w] <= r_count;
                    r_ref[r_w]   <= 1'b1;
                    r_count      <= r_count + STAMP_W'(1);
                    r_state      <= ST_RESP;
                end
                ST_RESP: begin
                    r_out.read_data <= (r_req.command == CMD_WRITE) ? '0 : $signed(ram_rdata);
                    r_out_valid     <= 1'b1;
                    r_state         <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_idle    = (r_state == ST_IDLE);
    assign o_dir.tag   = r_tag;
    assign o_dir.valid = r_valid;
    assign o_done    = r_out_valid;
    assign o_result  = r_out;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe longer than one cycle");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.hit && r_out.evicted))
        else $error("hit reported together with an eviction");

    a_line_installed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |=>
            (r_valid[$past(r_w)] && (r_tag[$past(r_w)] == $past(r_req.address))))
        else $error("accessed line not present after update");

endmodule

FILE: design/cache_directory_replacement.sv
// Top level of the fully associative cache directory with selectable
// replacement policy. Depends on cdr_pkg, cdr_front, cdr_queue and cdr_back.
//
// Usage: a transaction is offered on the i_ payload ports with start high and
// is taken at a rising edge where busy is low. Each transaction is one read or
// write access; exactly one result follows, shown for a single cycle with
// o_done high. The receiver cannot stall, so it must take the result in that
// cycle.
//
// Sequence: an accepted transaction is registered in the front end, pushed
// into the queue, taken by the back end and passed through its update and
// response states before the result strobe; that holds for a hit, a fill
// of a free way or a FIFO eviction. An LRU eviction adds a state that scans
// the stored stamps one way per cycle, and a clock eviction adds a state that
// tests one reference bit per cycle. The block works on one transaction at a
// time: busy stays high from acceptance until the result cycle, so a new
// transaction can be taken at the edge that ends the result strobe.
//
// Reset: i_rst_n is synchronous and active low. It clears the directory and
// pointers and sets the access counter to one. After reset the back end fills
// memory word i with i*10, one word per cycle, through all MEM_WORDS (16)
// words; busy is high throughout that fill.
module cache_directory_replacement (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_command,
    input  logic [3:0]          i_address,
    input  logic signed [31:0]  i_write_value,
    input  logic [1:0]          i_policy,
    input  logic                i_thru_mode,
    output logic                o_done,
    output logic                o_hit,
    output logic [1:0]          o_way,
    output logic signed [31:0]  o_read_data,
    output logic                o_evicted,
    output logic [3:0]          o_evicted_tag,
    output logic                o_evicted_dirty
);
    import cdr_pkg::*;

    logic      accept;
    logic      front_push;
    t_req      front_item;
    logic      q_valid;
    t_req      q_item;
    logic      back_pop;
    logic      back_idle;
    t_dir_view dir_view;
    t_result   result;

    // The front end may read the directory directly: only one transaction
    // is in flight, so the view is current when the lookup happens.
    assign accept = start && !busy;
    assign busy   = front_push || q_valid || !back_idle;

    cdr_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_command       (i_command),
        .i_address       (i_address),
        .i_write_value   (i_write_value),
        .i_policy        (i_policy),
        .i_thru_mode     (i_thru_mode),
        .i_dir           (dir_view),
        .o_push          (front_push),
        .o_item          (front_item)
    );

    cdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .i_pop   (back_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cdr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (back_pop),
        .o_idle    (back_idle),
        .o_dir     (dir_view),
        .o_done    (o_done),
        .o_result  (result)
    );

    // The way field on the port is the low bits of the way index.
    assign o_hit           = result.hit;
    assign o_way           = 2'(result.way);
    assign o_read_data     = result.read_data;
    assign o_evicted       = result.evicted;
    assign o_evicted_tag   = result.evicted_tag;
    assign o_evicted_dirty = result.evicted_dirty;

endmodule

FILE: tb/sv/cache_directory_replacement_tb.sv
// Self-checking testbench for cache_directory_replacement: a directed table of
// accesses then random traffic, each result checked as typed or by a local model.
// Depends on cdr_pkg and on the cache_directory_replacement RTL.
module cache_directory_replacement_tb;
    import cdr_pkg::*;

    // Codes that the package does not name.
    localparam logic             CMD_READ      = ~CMD_WRITE;
    localparam logic [POL_W-1:0] POL_LRU       = 2'd0;
    localparam logic [POL_W-1:0] POL_LRU_ALT   = 2'd3;
    localparam logic             MODE_COPYBACK = 1'b0;
    localparam logic             MODE_THRU     = 1'b1;

    localparam int     CLK_HALF        = 10;
    localparam int     RESET_CYCLES    = 9;
    localparam int     RANDOM_ACCESSES = 800;
    localparam int     PHASES          = 4;
    localparam int     MAX_GAP         = 40;
    // The slowest access is a clock eviction with a full sweep, so this leaves
    // ample time for a stray result to show up after the last one.
    localparam int     DRAIN_CYCLES    = 16;
    // Several times the slowest legal run, with the post-reset memory fill and
    // the longest sender gaps on every access.
    localparam longint WATCHDOG_TIME   = 5_000_000;

    // One access as the sender presents it.
    typedef struct packed {
        logic                     command;
        logic [TAG_W-1:0]         address;
        logic signed [DATA_W-1:0] write_value;
        logic [POL_W-1:0]         policy;
        logic                     thru_mode;
    } t_access;

    // A directed row: when typed is set, the result is written out by hand and
    // is checked as given; otherwise the model supplies the expectation.
    typedef struct packed {
        t_access acc;
        logic    typed;
        t_result known;
    } t_table_row;

    localparam logic    TYPED     = 1'b1;
    localparam logic    UNTYPED   = 1'b0;
    localparam t_result NO_RESULT = '0;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_command;
    logic [3:0]          i_address;
    logic signed [31:0]  i_write_value;
    logic [1:0]          i_policy;
    logic                i_thru_mode;
    logic                o_done;
    logic                o_hit;
    logic [1:0]          o_way;
    logic signed [31:0]  o_read_data;
    logic                o_evicted;
    logic [3:0]          o_evicted_tag;
    logic                o_evicted_dirty;

    cache_directory_replacement u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_write_value  (i_write_value),
        .i_policy       (i_policy),
        .i_thru_mode    (i_thru_mode),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_way          (o_way),
        .o_read_data    (o_read_data),
        .o_evicted      (o_evicted),
        .o_evicted_tag  (o_evicted_tag),
        .o_evicted_dirty(o_evicted_dirty)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Shadow copy of the directory, the replacement pointers and the memory.
    logic [TAG_W-1:0]         dir_tag   [WAYS];
    logic                     dir_valid [WAYS];
    logic                     dir_dirty [WAYS];
    logic                     dir_ref   [WAYS];
    logic [STAMP_W-1:0]       dir_stamp [WAYS];
    logic [WAY_W-1:0]         hand_ptr;
    logic [WAY_W-1:0]         fifo_ptr;
    logic [STAMP_W-1:0]       access_ctr;
    logic signed [DATA_W-1:0] mem_words [MEM_WORDS];

    // Expected results, oldest first, and a few figures for the summary.
    t_result pending_results[$];
    t_table_row access_table[$];
    int mismatch_count = 0;
    int accepted_count = 0;
    int results_seen   = 0;
    int hit_count      = 0;
    int lru_victims    = 0;
    int fifo_victims   = 0;
    int clock_victims  = 0;
    int dirty_victims  = 0;

    function automatic logic [WAY_W-1:0] way_next(input logic [WAY_W-1:0] p);
        return WAY_W'((int'(p) + 1) % WAYS);
    endfunction

    // Applies one access to the shadow state and returns the result that the
    // block should report for it.
    function automatic t_result predict_access(input t_access a);
        t_result          r;
        logic [WAY_W-1:0] w;
        logic [WAY_W-1:0] p;
        logic             found;
        int               k;
        int               n;
        r     = '0;
        w     = '0;
        found = 1'b0;
        for (k = 0; k < WAYS; k++) begin
            if (!found && dir_valid[k] && dir_tag[k] == a.address) begin
                found = 1'b1;
                w     = WAY_W'(k);
            end
        end
        r.hit = found;
        if (!found) begin
            // The lowest free way wins before any policy is consulted.
            for (k = 0; k < WAYS; k++) begin
                if (!found && !dir_valid[k]) begin
                    found = 1'b1;
                    w     = WAY_W'(k);
                end
            end
            if (!found) begin
                if (a.policy == POL_FIFO) begin
                    w        = fifo_ptr;
                    fifo_ptr = way_next(fifo_ptr);
                    fifo_victims++;
                end else if (a.policy == POL_CLOCK) begin
                    // Second chance: clear set bits until a clear one turns up.
                    p = hand_ptr;
                    for (n = 0; n <= WAYS; n++) begin
                        if (!found) begin
                            if (!dir_ref[p]) begin
                                found = 1'b1;
                            end else begin
                                dir_ref[p] = 1'b0;
                                p          = way_next(p);
                            end
                        end
                    end
                    w        = p;
                    hand_ptr = way_next(p);
                    clock_victims++;
                end else begin
                    // LRU, and the spare policy code too; ties go to the lower way.
                    w = '0;
                    for (k = 1; k < WAYS; k++) begin
                        if (dir_stamp[k] < dir_stamp[w]) begin
                            w = WAY_W'(k);
                        end
                    end
                    lru_victims++;
                end
                r.evicted       = 1'b1;
                r.evicted_tag   = dir_tag[w];
                r.evicted_dirty = dir_dirty[w];
                if (dir_dirty[w]) begin
                    dirty_victims++;
                end
            end
            dir_tag[w]   = a.address;
            dir_valid[w] = 1'b1;
            dir_dirty[w] = 1'b0;
        end
        dir_stamp[w] = access_ctr;
        dir_ref[w]   = 1'b1;
        access_ctr   = access_ctr + STAMP_W'(1);
        // Memory is always current; write-through leaves a dirty line dirty.
        if (a.command == CMD_WRITE) begin
            if (a.thru_mode == MODE_COPYBACK) begin
                dir_dirty[w] = 1'b1;
            end
            mem_words[int'(a.address) % MEM_WORDS] = a.write_value;
        end
        r.way       = w;
        r.read_data = (a.command == CMD_WRITE) ? '0 : mem_words[int'(a.address) % MEM_WORDS];
        return r;
    endfunction

    // Presents one transaction after a random idle gap and holds it until the
    // block takes it. Returns at the accepting edge with start still high, so
    // the caller either presents the next access or lowers start in this step.
    task automatic send_access(input t_access a, input logic typed, input t_result known,
                               input int gap_pct);
        int      gap;
        t_result predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_command       <= a.command;
        i_address       <= a.address;
        i_write_value   <= a.write_value;
        i_policy        <= a.policy;
        i_thru_mode     <= a.thru_mode;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = predict_access(a);
        if (predicted.hit) begin
            hit_count++;
        end
        pending_results.push_back(typed ? known : predicted);
        accepted_count++;
    endtask

    task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            mismatch_count++;
        end
    endtask

    // Results cannot be held off, so every strobe is taken at the edge that
    // ends it and compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with nothing pending");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("hit", DATA_W'(want.hit), DATA_W'(o_hit));
                check_field("way", DATA_W'(want.way), DATA_W'(o_way));
                check_field("read_data", want.read_data, o_read_data);
                check_field("evicted", DATA_W'(want.evicted), DATA_W'(o_evicted));
                check_field("evicted_tag", DATA_W'(want.evicted_tag), DATA_W'(o_evicted_tag));
                check_field("evicted_dirty", DATA_W'(want.evicted_dirty),
                            DATA_W'(o_evicted_dirty));
            end
        end
    end

    initial begin
        t_access          a;
        int               i;
        int               ph;
        int               gap_pct;
        logic [POL_W-1:0] cur_policy;
        logic [TAG_W-1:0] hot_base;

        // Shadow state after reset: empty directory, counter at one and the
        // memory holding ten times each word's index.
        for (i = 0; i < WAYS; i++) begin
            dir_tag[i]   = '0;
            dir_valid[i] = 1'b0;
            dir_dirty[i] = 1'b0;
            dir_ref[i]   = 1'b0;
            dir_stamp[i] = '0;
        end
        hand_ptr   = '0;
        fifo_ptr   = '0;
        access_ctr = STAMP_W'(1);
        for (i = 0; i < MEM_WORDS; i++) begin
            mem_words[i] = DATA_W'(i * 10);
        end

        i_rst_n         <= 1'b0;
        start           <= 1'b0;
        i_command       <= CMD_READ;
        i_address       <= '0;
        i_write_value   <= '0;
        i_policy        <= POL_LRU;
        i_thru_mode     <= MODE_COPYBACK;

        // The first rows fill the four ways from empty and can be worked out by
        // hand: word 15 reads 150, a fill into a free way ignores the policy, and
        // the first LRU eviction takes way 0, the oldest line.
        access_table.push_back({CMD_READ, 4'd0, 32'sd0, POL_LRU, MODE_COPYBACK,
                                TYPED, 1'b0, 2'd0, 32'd0, 1'b0, 4'd0, 1'b0});
        access_table.push_back({CMD_READ, 4'd15, 32'sd0, POL_LRU, MODE_COPYBACK,
                                TYPED, 1'b0, 2'd1, 32'd150, 1'b0, 4'd0, 1'b0});
        access_table.push_back({CMD_WRITE, 4'd3, 32'sh7FFFFFFF, POL_LRU, MODE_COPYBACK,
                                TYPED, 1'b0, 2'd2, 32'd0, 1'b0, 4'd0, 1'b0});
        access_table.push_back({CMD_WRITE, 4'd15, 32'sh80000000, POL_FIFO, MODE_THRU,
                                TYPED, 1'b1, 2'd1, 32'd0, 1'b0, 4'd0, 1'b0});
        access_table.push_back({CMD_READ, 4'd15, 32'shFFFFFFFF, POL_CLOCK, MODE_THRU,
                                TYPED, 1'b1, 2'd1, 32'h80000000, 1'b0, 4'd0, 1'b0});
        access_table.push_back({CMD_READ, 4'd5, 32'sd0, POL_LRU_ALT, MODE_COPYBACK,
                                TYPED, 1'b0, 2'd3, 32'd50, 1'b0, 4'd0, 1'b0});
        access_table.push_back({CMD_READ, 4'd7, 32'sd0, POL_LRU, MODE_COPYBACK,
                                TYPED, 1'b0, 2'd0, 32'd70, 1'b1, 4'd0, 1'b0});
        access_table.push_back({CMD_READ, 4'd3, 32'sd0, POL_LRU, MODE_COPYBACK,
                                TYPED, 1'b1, 2'd2, 32'h7FFFFFFF, 1'b0, 4'd0, 1'b0});
        // From here the model predicts: write-through onto a dirty line, the
        // spare policy code, FIFO victims, a clock sweep over all set reference
        // bits, and dirty lines being evicted.
        access_table.push_back({CMD_WRITE, 4'd3, 32'sd0, POL_LRU, MODE_THRU,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_WRITE, 4'd5, -32'sd1, POL_LRU, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd9, 32'sd0, POL_LRU_ALT, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd11, 32'sd0, POL_FIFO, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd12, 32'sd0, POL_FIFO, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd13, 32'sd0, POL_CLOCK, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd14, 32'sd0, POL_CLOCK, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_WRITE, 4'd2, 32'sh12345678, POL_CLOCK, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd3, 32'sd0, POL_FIFO, MODE_THRU,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_WRITE, 4'd6, 32'sd1, POL_LRU_ALT, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd6, 32'sd0, POL_LRU, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd15, 32'sd0, POL_FIFO, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_WRITE, 4'd10, 32'sh55555555, POL_CLOCK, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd10, 32'sd0, POL_LRU, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});
        access_table.push_back({CMD_READ, 4'd5, 32'sd0, POL_CLOCK, MODE_COPYBACK,
                                UNTYPED, NO_RESULT});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Busy covers the memory fill after reset, so the first row simply
        // waits for it.
        for (i = 0; i < access_table.size(); i++) begin
            send_access(access_table[i].acc, access_table[i].typed, access_table[i].known, 27);
        end

        // Random traffic. Addresses mostly come from a sliding window of six,
        // a little wider than the directory, so hits and evictions both stay
        // frequent; the policy sticks for a while so FIFO and clock pointers
        // build up history. Phases differ only in how often the sender idles.
        cur_policy = POL_LRU;
        hot_base   = '0;
        for (ph = 0; ph < PHASES; ph++) begin
            gap_pct = (ph == 1) ? 61 : (ph == 3) ? 27 : 0;
            for (i = 0; i < RANDOM_ACCESSES / PHASES; i++) begin
                if ($urandom_range(15) == 0) begin
                    cur_policy = POL_W'($urandom_range(3));
                end
                if ($urandom_range(7) == 0) begin
                    hot_base = TAG_W'($urandom_range(15));
                end
                a.command = 1'($urandom_range(1));
                if ($urandom_range(9) < 6) begin
                    a.address = TAG_W'(int'(hot_base) + $urandom_range(5));
                end else begin
                    a.address = TAG_W'($urandom_range(15));
                end
                case ($urandom_range(7))
                    0: a.write_value = '0;
                    1: a.write_value = -32'sd1;
                    2: a.write_value = 32'sh7FFFFFFF;
                    3: a.write_value = 32'sh80000000;
                    default: a.write_value = $urandom;
                endcase
                a.policy    = ($urandom_range(4) == 0) ? POL_W'($urandom_range(3)) : cur_policy;
                a.thru_mode = 1'($urandom_range(1));
                send_access(a, UNTYPED, NO_RESULT, gap_pct);
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d accesses (%0d from the directed table), %0d results checked, %0d hits.",
                 accepted_count, access_table.size(), results_seen, hit_count);
        $display("Victims chosen: %0d by LRU, %0d by FIFO, %0d by clock; %0d of them dirty.",
                 lru_victims, fifo_victims, clock_victims, dirty_victims);
        if (mismatch_count == 0) begin
            $display("cache_directory_replacement_tb: done, clean");
        end else begin
            $display("cache_directory_replacement_tb: done, errors");
        end
        $finish;
    end

    // Hard stop in case the block hangs and a handshake never completes.
    initial begin
        #(WATCHDOG_TIME);
        $display("cache_directory_replacement_tb: done, errors");
        $finish;
    end

endmodule
